FILE: rtl/cpid_pkg.sv
// shared types, sizes and helpers for the clamped pid controller
// no dependencies; every other file uses this package
package cpid_pkg;

  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int LimW    = DataW - 1;
  localparam int ErrW    = DataW + 1;
  localparam int ProdW   = DataW + ErrW;
  localparam int WideW   = ProdW - FracW + 1;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_LIMIT_P     = 3'd3,
    CFG_LIMIT_I     = 3'd4,
    CFG_LIMIT_D     = 3'd5,
    CFG_LIMIT_OUT   = 3'd6,
    CFG_LIMIT_ACCUM = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic [LimW-1:0]         limit_p;
    logic [LimW-1:0]         limit_i;
    logic [LimW-1:0]         limit_d;
    logic [LimW-1:0]         limit_out;
    logic [LimW-1:0]         limit_accum;
  } cfg_t;

  // error, measurement change and updated accumulator of one word
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [ErrW-1:0]  diff;
    logic signed [DataW-1:0] accum;
  } sig_t;

  // full-precision gain products
  typedef struct packed {
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] i;
    logic signed [ProdW-1:0] d;
  } prod_t;

  // symmetric saturation to +-lim
  function automatic logic signed [DataW-1:0] clamp_sym(input logic signed [WideW-1:0] x,
                                                        input logic [LimW-1:0] lim);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic signed [DataW-1:0] r;
    hi = $signed({{(WideW-LimW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      r = hi[DataW-1:0];
    end else if (x < lo) begin
      r = lo[DataW-1:0];
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/cpid_if.sv
// valid/ready channel interfaces for the clamped pid controller
// depends on cpid_pkg for the field widths
interface cpid_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [cpid_pkg::DataW-1:0] setpoint;
  logic signed [cpid_pkg::DataW-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface cpid_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cpid_pkg::DataW-1:0] drive;
  logic signed [cpid_pkg::DataW-1:0] term_p;
  logic signed [cpid_pkg::DataW-1:0] term_i;
  logic signed [cpid_pkg::DataW-1:0] term_d;

  modport source (output valid, output drive, output term_p, output term_i, output term_d,
                  input ready);
  modport sink   (input valid, input drive, input term_p, input term_i, input term_d,
                  output ready);
endinterface

FILE: rtl/cpid_cfg_regs.sv
// gain and limit register file, written through a plain write port
// depends on cpid_pkg
module cpid_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpid_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpid_pkg::DataW-1:0]      cfg_data_i,
  output cpid_pkg::cfg_t                  cfg_o
);
  import cpid_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:      cfg_d.gain_p      = $signed(cfg_data_i);
        CFG_GAIN_I:      cfg_d.gain_i      = $signed(cfg_data_i);
        CFG_GAIN_D:      cfg_d.gain_d      = $signed(cfg_data_i);
        CFG_LIMIT_P:     cfg_d.limit_p     = cfg_data_i[LimW-1:0];
        CFG_LIMIT_I:     cfg_d.limit_i     = cfg_data_i[LimW-1:0];
        CFG_LIMIT_D:     cfg_d.limit_d     = cfg_data_i[LimW-1:0];
        CFG_LIMIT_OUT:   cfg_d.limit_out   = cfg_data_i[LimW-1:0];
        CFG_LIMIT_ACCUM: cfg_d.limit_accum = cfg_data_i[LimW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/cpid_front.sv
// input register, error/derivative forming and the integral state
// depends on cpid_pkg and cpid_in_if
module cpid_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  cpid_in_if.sink        in_i,
  input  cpid_pkg::cfg_t cfg_i,
  output logic           s1_valid_o,
  input  logic           s1_ready_i,
  output cpid_pkg::sig_t s1_o
);
  import cpid_pkg::*;

  logic                    s0_v_q;
  logic                    s1_v_q;
  logic signed [DataW-1:0] sp_q;
  logic signed [DataW-1:0] ms_q;
  logic signed [DataW-1:0] accum_q;
  logic signed [DataW-1:0] accum_d;
  logic signed [DataW-1:0] prev_sp_q;
  logic signed [DataW-1:0] prev_ms_q;
  sig_t                    s1_q;
  sig_t                    s1_d;
  logic signed [WideW-1:0] sum_w;
  logic                    s0_ready;
  logic                    s1_ready;
  logic                    s0_adv;

  assign s1_ready   = !s1_v_q || s1_ready_i;
  assign s0_ready   = !s0_v_q || s1_ready;
  assign s0_adv     = s0_v_q && s1_ready;
  assign in_i.ready = s0_ready;

  always_comb begin
    s1_d.err  = ErrW'(sp_q) - ErrW'(ms_q);
    s1_d.diff = ErrW'(ms_q) - ErrW'(prev_ms_q);
    sum_w     = WideW'(accum_q) + WideW'(s1_d.err);
    // a new setpoint restarts the integral
    if (sp_q != prev_sp_q) begin
      accum_d = '0;
    end else begin
      accum_d = clamp_sym(sum_w, cfg_i.limit_accum);
    end
    s1_d.accum = accum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_v_q <= in_i.valid;
      end
      if (s1_ready) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s0_ready) begin
      sp_q <= in_i.setpoint;
      ms_q <= in_i.measured;
    end
    if (s0_adv) begin
      s1_q <= s1_d;
    end
  end

  // controller state moves exactly once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q   <= '0;
      prev_sp_q <= '0;
      prev_ms_q <= '0;
    end else if (s0_adv) begin
      accum_q   <= accum_d;
      prev_sp_q <= sp_q;
      prev_ms_q <= ms_q;
    end
  end

  assign s1_valid_o = s1_v_q;
  assign s1_o       = s1_q;

  a_setpoint_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && (sp_q != prev_sp_q) |=> (accum_q == '0) && (s1_q.accum == '0))
    else $error("integral not cleared on setpoint change");

  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv |=> (prev_ms_q == $past(ms_q)) && (prev_sp_q == $past(sp_q)))
    else $error("previous sample not captured");

  a_s0_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_v_q && !s1_ready |=> s0_v_q && $stable(sp_q) && $stable(ms_q))
    else $error("input stage lost a word under stall");

endmodule

FILE: rtl/cpid_mult.sv
// gain multiply stage: three signed products registered at full precision
// depends on cpid_pkg
module cpid_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpid_pkg::cfg_t  cfg_i,
  input  logic            s1_valid_i,
  output logic            s1_ready_o,
  input  cpid_pkg::sig_t  s1_i,
  output logic            s2_valid_o,
  input  logic            s2_ready_i,
  output cpid_pkg::prod_t s2_o
);
  import cpid_pkg::*;

  logic  s2_v_q;
  prod_t s2_q;
  prod_t s2_d;
  logic  s2_ready;

  assign s2_ready   = !s2_v_q || s2_ready_i;
  assign s1_ready_o = s2_ready;

  always_comb begin
    s2_d.p = $signed(cfg_i.gain_p) * $signed(s1_i.err);
    s2_d.i = $signed(cfg_i.gain_i) * $signed(s1_i.accum);
    s2_d.d = $signed(cfg_i.gain_d) * $signed(s1_i.diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_v_q;
  assign s2_o       = s2_q;

endmodule

FILE: rtl/cpid_out.sv
// scaling, term saturation, drive sum and the result register
// depends on cpid_pkg and cpid_out_if
module cpid_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpid_pkg::cfg_t  cfg_i,
  input  logic            s2_valid_i,
  output logic            s2_ready_o,
  input  cpid_pkg::prod_t s2_i,
  cpid_out_if.source      out_o
);
  import cpid_pkg::*;

  logic                    out_v_q;
  logic                    out_ready;
  logic signed [DataW-1:0] tp_d;
  logic signed [DataW-1:0] ti_d;
  logic signed [DataW-1:0] td_d;
  logic signed [DataW-1:0] drv_d;
  logic signed [WideW-1:0] sum_w;
  logic signed [DataW-1:0] drive_q;
  logic signed [DataW-1:0] tp_q;
  logic signed [DataW-1:0] ti_q;
  logic signed [DataW-1:0] td_q;

  assign out_ready  = !out_v_q || out_o.ready;
  assign s2_ready_o = out_ready;

  // dropping the fraction bits of a two's complement product floors it
  always_comb begin
    tp_d  = clamp_sym(WideW'($signed(s2_i.p[ProdW-1:FracW])), cfg_i.limit_p);
    ti_d  = clamp_sym(WideW'($signed(s2_i.i[ProdW-1:FracW])), cfg_i.limit_i);
    td_d  = clamp_sym(WideW'($signed(s2_i.d[ProdW-1:FracW])), cfg_i.limit_d);
    sum_w = WideW'(tp_d) + WideW'(ti_d) - WideW'(td_d);
    drv_d = clamp_sym(sum_w, cfg_i.limit_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_i && out_ready) begin
      drive_q <= drv_d;
      tp_q    <= tp_d;
      ti_q    <= ti_d;
      td_q    <= td_d;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.drive  = drive_q;
  assign out_o.term_p = tp_q;
  assign out_o.term_i = ti_q;
  assign out_o.term_d = td_q;

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_o.ready |=> out_v_q && $stable(drive_q) && $stable(ti_q))
    else $error("result word changed while stalled");

endmodule

FILE: rtl/clamped_pid_controller_top.sv
// clamped pid controller: one setpoint/measurement word in, one drive word out
// usage: push {setpoint, measured} on in_i (valid/ready); each accepted word
// yields exactly one result word on out_o with drive, term_p, term_i, term_d,
// all signed Q16.16. gains and limits are written through cfg_we_i/cfg_idx_i/
// cfg_data_i while no word is in flight.
// path: an accepted word passes the input register, error register, product register
// and result register in that order; the accepting edge loads the input register.
// throughput: one word per cycle unless out_o stalls; the integral and previous
// samples update as a word leaves the input register, so the next word sees them.
// reset: all gains, limits, the integral and the previous samples clear to 0;
// all pipeline stages empty.
// stall: when out_o.ready is low the result word holds; the four stages keep
// filling and in_i.ready drops only when all of them are occupied.
// depends on cpid_pkg, cpid_if and the cpid_* submodules
module clamped_pid_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cpid_in_if.sink                      in_i,
  cpid_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [cpid_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cpid_pkg::DataW-1:0]   cfg_data_i
);
  import cpid_pkg::*;

  cfg_t  cfg;
  sig_t  s1;
  prod_t s2;
  logic  s1_valid;
  logic  s1_ready;
  logic  s2_valid;
  logic  s2_ready;

  cpid_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cpid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  cpid_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  cpid_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s2_valid_i (s2_valid),
    .s2_ready_o (s2_ready),
    .s2_i       (s2),
    .out_o      (out_o)
  );

endmodule
